>>> sv/bpc_pkg.sv
// Shared types and constants for the barometric pressure compensation block.
package bpc_pkg;

  localparam int unsigned RawW    = 16;
  localparam int unsigned DropW   = 6;
  localparam int unsigned CountW  = RawW - DropW;
  localparam int unsigned CoefW   = 16;
  localparam int unsigned AccW    = 32;
  localparam int unsigned CfgIdxW = 3;

  localparam int unsigned ShA11    = 14;
  localparam int unsigned ShA1     = 11;
  localparam int unsigned ShA2Coef = 15;
  localparam int unsigned ShA2     = 16;
  localparam int unsigned ShY1     = 10;
  localparam int unsigned ShAlign  = 10;
  localparam int unsigned DivShift = 13;

  // Register indexes of the configuration port.
  typedef enum logic [CfgIdxW-1:0] {
    CfgA0  = 3'd0,
    CfgB1  = 3'd1,
    CfgB2  = 3'd2,
    CfgC12 = 3'd3,
    CfgC11 = 3'd4,
    CfgC22 = 3'd5
  } cfg_idx_e;

  // The six calibration coefficients.
  typedef struct packed {
    logic signed [CoefW-1:0] a0;
    logic signed [CoefW-1:0] b1;
    logic signed [CoefW-1:0] b2;
    logic signed [CoefW-1:0] c12;
    logic signed [CoefW-1:0] c11;
    logic signed [CoefW-1:0] c22;
  } coef_t;

  // Last polynomial stage handed to the output stage.
  typedef struct packed {
    logic                  valid;
    logic signed [AccW-1:0] value;
  } sum_t;

endpackage

>>> sv/bpc_coef_regs.sv
// Calibration coefficient registers written through the configuration port.
module bpc_coef_regs (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_valid_i,
  input  logic [bpc_pkg::CfgIdxW-1:0]    cfg_index_i,
  input  logic [bpc_pkg::CoefW-1:0]      cfg_data_i,
  output bpc_pkg::coef_t                 coef_o
);

  bpc_pkg::coef_t coef_q, coef_d;

  always_comb begin
    coef_d = coef_q;
    if (cfg_valid_i) begin
      unique case (bpc_pkg::cfg_idx_e'(cfg_index_i))
        bpc_pkg::CfgA0:  coef_d.a0  = cfg_data_i;
        bpc_pkg::CfgB1:  coef_d.b1  = cfg_data_i;
        bpc_pkg::CfgB2:  coef_d.b2  = cfg_data_i;
        bpc_pkg::CfgC12: coef_d.c12 = cfg_data_i;
        bpc_pkg::CfgC11: coef_d.c11 = cfg_data_i;
        bpc_pkg::CfgC22: coef_d.c22 = cfg_data_i;
        default:         coef_d     = coef_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      coef_q <= '0;
    end else begin
      coef_q <= coef_d;
    end
  end

  assign coef_o = coef_q;

endmodule

>>> sv/bpc_poly_pipe.sv
// Five-stage pipeline that evaluates the compensation polynomial.
module bpc_poly_pipe (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         en_i,
  input  logic                         valid_i,
  input  logic [bpc_pkg::RawW-1:0]     pressure_raw_i,
  input  logic [bpc_pkg::RawW-1:0]     temperature_raw_i,
  input  bpc_pkg::coef_t               coef_i,
  output bpc_pkg::sum_t                sum_o
);

  localparam int unsigned W = bpc_pkg::AccW;
  localparam int unsigned CW = bpc_pkg::CountW;

  // Valid bits for stages one to five.
  logic [4:0] vld_q, vld_d;

  // Stage 1: counts and first-order products.
  logic [CW-1:0]         s1_padc_q, s1_tadc_q;
  logic signed [26:0]    s1_p11_q, s1_p12_q, s1_p22_q;
  // Stage 2: a11 and a2.
  logic [CW-1:0]         s2_padc_q, s2_tadc_q;
  logic signed [17:0]    s2_a11_q;
  logic signed [15:0]    s2_a2_q;
  logic signed [26:0]    s2_p12_q;
  // Stage 3: a1.
  logic [CW-1:0]         s3_padc_q, s3_tadc_q;
  logic signed [18:0]    s3_a1_q;
  logic signed [15:0]    s3_a2_q;
  // Stage 4: second products.
  logic signed [29:0]    s4_m1_q;
  logic signed [26:0]    s4_m2_q;
  // Stage 5: full sum before division.
  logic signed [W-1:0]   s5_v_q;

  logic [CW-1:0]         padc, tadc;
  logic signed [26:0]    p11, p12, p22;
  logic signed [W-1:0]   sum_a11, sum_a2, sum_a1, sum_y1, y1_al, v;
  logic signed [17:0]    a11;
  logic signed [15:0]    a2;
  logic signed [18:0]    a1;
  logic signed [29:0]    m1;
  logic signed [26:0]    m2;
  logic signed [20:0]    y1;

  always_comb begin
    padc = pressure_raw_i[bpc_pkg::RawW-1:bpc_pkg::DropW];
    tadc = temperature_raw_i[bpc_pkg::RawW-1:bpc_pkg::DropW];
    p11  = coef_i.c11 * $signed({1'b0, padc});
    p12  = coef_i.c12 * $signed({1'b0, tadc});
    p22  = coef_i.c22 * $signed({1'b0, tadc});

    sum_a11 = (W'(coef_i.b1) <<< bpc_pkg::ShA11) + W'(s1_p11_q);
    a11     = 18'(sum_a11 >>> bpc_pkg::ShA11);
    sum_a2  = (W'(coef_i.b2) <<< bpc_pkg::ShA2Coef) + W'(s1_p22_q >>> 1);
    a2      = 16'(sum_a2 >>> bpc_pkg::ShA2);

    sum_a1 = (W'(s2_a11_q) <<< bpc_pkg::ShA1) + W'(s2_p12_q);
    a1     = 19'(sum_a1 >>> bpc_pkg::ShA1);

    m1 = s3_a1_q * $signed({1'b0, s3_padc_q});
    m2 = s3_a2_q * $signed({1'b0, s3_tadc_q});

    sum_y1 = (W'(coef_i.a0) <<< bpc_pkg::ShY1) + W'(s4_m1_q);
    y1     = 21'(sum_y1 >>> bpc_pkg::ShY1);
    y1_al  = W'(y1) <<< bpc_pkg::ShAlign;
    v      = y1_al + W'(s4_m2_q);
  end

  assign vld_d = {vld_q[3:0], valid_i};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s1_padc_q <= padc;
      s1_tadc_q <= tadc;
      s1_p11_q  <= p11;
      s1_p12_q  <= p12;
      s1_p22_q  <= p22;

      s2_padc_q <= s1_padc_q;
      s2_tadc_q <= s1_tadc_q;
      s2_a11_q  <= a11;
      s2_a2_q   <= a2;
      s2_p12_q  <= s1_p12_q;

      s3_padc_q <= s2_padc_q;
      s3_tadc_q <= s2_tadc_q;
      s3_a1_q   <= a1;
      s3_a2_q   <= s2_a2_q;

      s4_m1_q   <= m1;
      s4_m2_q   <= m2;

      s5_v_q    <= v;
    end
  end

  assign sum_o.valid = vld_q[4];
  assign sum_o.value = s5_v_q;

endmodule

>>> sv/bpc_div_out.sv
// Output stage: signed divide by 8192 toward zero and the result register.
module bpc_div_out (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  bpc_pkg::sum_t                     sum_i,
  input  logic                              out_ready_i,
  output logic                              en_o,
  output logic                              out_valid_o,
  output logic signed [bpc_pkg::CoefW-1:0]  compensated_pressure_o
);

  localparam int unsigned W = bpc_pkg::AccW;

  logic                             out_valid_q;
  logic signed [bpc_pkg::CoefW-1:0] out_data_q, out_data_d;
  logic signed [W-1:0]              bias, quot;

  // Adding 2^13-1 to a negative value makes the arithmetic shift round toward zero.
  always_comb begin
    bias       = $signed({{(W-bpc_pkg::DivShift){1'b0}}, {bpc_pkg::DivShift{sum_i.value[W-1]}}});
    quot       = (sum_i.value + bias) >>> bpc_pkg::DivShift;
    out_data_d = quot[bpc_pkg::CoefW-1:0];
  end

  assign en_o = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en_o) begin
      out_valid_q <= sum_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_o) begin
      out_data_q <= out_data_d;
    end
  end

  assign out_valid_o            = out_valid_q;
  assign compensated_pressure_o = out_data_q;

endmodule

>>> sv/barometric_pressure_compensation.sv
// Top level of the fixed-point barometric pressure compensation block.
//
// This block turns one pair of raw 16-bit pressure and temperature converter
// words into one signed 16-bit compensated pressure count. The low six bits of
// each raw word are dropped, and the remaining 10-bit counts go through the
// sensor's calibration polynomial using the six coefficients held in the
// configuration registers. A new request is taken every clock cycle while the
// output side keeps up. Each result passes through five polynomial stages and
// the divide-by-8192 output register. Each polynomial stage holds either up to
// three small multiplies or up to two add-and-shift steps. When the output is
// stalled the whole pipeline holds, so in_ready_o follows out_ready_i whenever
// a result is waiting. Coefficients are written one per cycle through the
// configuration port (cfg_ready_o is always high); writes to an index above
// five are dropped, and they are meant to be written only while no request is
// in flight.

module barometric_pressure_compensation (
  input  logic                              clk_i,
  input  logic                              rst_ni,

  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [bpc_pkg::CfgIdxW-1:0]       cfg_index_i,
  input  logic [bpc_pkg::CoefW-1:0]         cfg_data_i,

  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic [bpc_pkg::RawW-1:0]          pressure_raw_i,
  input  logic [bpc_pkg::RawW-1:0]          temperature_raw_i,

  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic signed [bpc_pkg::CoefW-1:0]  compensated_pressure_o
);

  bpc_pkg::coef_t coef;
  bpc_pkg::sum_t  sum;
  logic           en;

  // Configuration writes are never stalled.
  assign cfg_ready_o = 1'b1;

  bpc_coef_regs u_coef_regs (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .coef_o      (coef)
  );

  // The pipeline advances whenever the output register is empty or being drained.
  assign in_ready_o = en;

  bpc_poly_pipe u_poly_pipe (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .en_i              (en),
    .valid_i           (in_valid_i),
    .pressure_raw_i    (pressure_raw_i),
    .temperature_raw_i (temperature_raw_i),
    .coef_i            (coef),
    .sum_o             (sum)
  );

  bpc_div_out u_div_out (
    .clk_i                  (clk_i),
    .rst_ni                 (rst_ni),
    .sum_i                  (sum),
    .out_ready_i            (out_ready_i),
    .en_o                   (en),
    .out_valid_o            (out_valid_o),
    .compensated_pressure_o (compensated_pressure_o)
  );

endmodule

>>> tb/tb.sv
// Self-checking testbench for the barometric pressure compensation block.
`timescale 1ns / 1ps

module tb;
  import bpc_pkg::*;

  // The two register indexes past the coefficient set, which the block drops.
  localparam logic [CfgIdxW-1:0] CfgSpare6 = 3'd6;
  localparam logic [CfgIdxW-1:0] CfgSpare7 = 3'd7;

  localparam int RandomPhases  = 10;
  localparam int PhaseRequests = 175;
  // One long receiver hold-off, started once this many results have come back.
  localparam int LongHoldAt    = 500;
  localparam int LongHoldLen   = 80;
  // The pipeline is six stages deep; this covers it with margin.
  localparam int DrainCycles   = 12;
  // Longest correct quiet stretch is the long hold plus a few short bursts.
  localparam int WatchdogLimit = 2000;

  typedef struct packed {
    logic [RawW-1:0] pressure;
    logic [RawW-1:0] temperature;
  } sample_t;

  logic                     clk_i;
  logic                     rst_ni = 1'b0;
  logic                     cfg_valid_i = 1'b0;
  logic                     cfg_ready_o;
  logic [CfgIdxW-1:0]       cfg_index_i = '0;
  logic [CoefW-1:0]         cfg_data_i = '0;
  logic                     in_valid_i = 1'b0;
  logic                     in_ready_o;
  logic [RawW-1:0]          pressure_raw_i = '0;
  logic [RawW-1:0]          temperature_raw_i = '0;
  logic                     out_valid_o;
  logic                     out_ready_i = 1'b0;
  logic signed [CoefW-1:0]  compensated_pressure_o;

  barometric_pressure_compensation DUT (
    .clk_i                  (clk_i),
    .rst_ni                 (rst_ni),
    .cfg_valid_i            (cfg_valid_i),
    .cfg_ready_o            (cfg_ready_o),
    .cfg_index_i            (cfg_index_i),
    .cfg_data_i             (cfg_data_i),
    .in_valid_i             (in_valid_i),
    .in_ready_o             (in_ready_o),
    .pressure_raw_i         (pressure_raw_i),
    .temperature_raw_i      (temperature_raw_i),
    .out_valid_o            (out_valid_o),
    .out_ready_i            (out_ready_i),
    .compensated_pressure_o (compensated_pressure_o)
  );

  // Testbench copy of the calibration registers, updated on each accepted write.
  coef_t calib = '0;

  sample_t                 sample_q[$];
  logic signed [CoefW-1:0] expected_pressure_q[$];

  int  requests_queued = 0;
  int  results_seen    = 0;
  int  mismatches      = 0;
  int  idle_pct        = 0;
  int  send_gap        = 0;
  int  hold_left       = 0;
  int  stall_cycles    = 0;
  bit  long_hold_done  = 1'b0;
  logic in_taken       = 1'b0;

  int idle_plan[RandomPhases] = '{20, 0, 40, 10, 30, 0, 25, 15, 0, 0};

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // Compensation polynomial in 32-bit wrapping signed arithmetic. Every term is
  // an int, so products and shifted sums wrap and >>> stays arithmetic.
  function automatic logic signed [CoefW-1:0] compensate(coef_t k, logic [RawW-1:0] p_raw,
                                                         logic [RawW-1:0] t_raw);
    int pc, tc, a11, a1, a2, y1, acc;
    pc  = int'(p_raw[RawW-1:DropW]);
    tc  = int'(t_raw[RawW-1:DropW]);
    a11 = ((int'(k.b1) <<< ShA11) + int'(k.c11) * pc) >>> ShA11;
    a1  = ((a11 <<< ShA1) + int'(k.c12) * tc) >>> ShA1;
    a2  = ((int'(k.b2) <<< ShA2Coef) + ((int'(k.c22) * tc) >>> 1)) >>> ShA2;
    y1  = ((int'(k.a0) <<< ShY1) + a1 * pc) >>> ShY1;
    acc = (y1 <<< ShAlign) + a2 * tc;
    // Signed int division truncates toward zero, as the sensor math expects.
    acc = acc / (1 <<< DivShift);
    return acc[CoefW-1:0];
  endfunction

  // Drives one register write and waits for its handshake. The valid stays high
  // so back-to-back writes follow without a gap; load_coefs lowers it afterwards.
  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [CoefW-1:0] data);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (cfg_idx_e'(idx))
      CfgA0:   calib.a0  = data;
      CfgB1:   calib.b1  = data;
      CfgB2:   calib.b2  = data;
      CfgC12:  calib.c12 = data;
      CfgC11:  calib.c11 = data;
      CfgC22:  calib.c22 = data;
      default: ;
    endcase
  endtask

  // Loads a full coefficient set, then pokes one of the unused indexes with
  // random data, which must leave every coefficient alone.
  task automatic load_coefs(coef_t k);
    write_reg(CfgC22, k.c22);
    write_reg(CfgA0, k.a0);
    write_reg(CfgC11, k.c11);
    write_reg(CfgB1, k.b1);
    write_reg(CfgC12, k.c12);
    write_reg(CfgB2, k.b2);
    write_reg($urandom_range(1) ? CfgSpare6 : CfgSpare7, CoefW'($urandom));
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic queue_sample(logic [RawW-1:0] p, logic [RawW-1:0] t);
    sample_q.push_back('{pressure: p, temperature: t});
    requests_queued++;
  endtask

  // The block is idle once every queued request has produced its result.
  task automatic wait_drained();
    while (results_seen != requests_queued) @(posedge clk_i);
  endtask

  // The corners of the two raw words: zero and full counts, with the ignored
  // low bits both clear and set.
  task automatic queue_corners();
    queue_sample(16'h0000, 16'h0000);
    queue_sample(16'hFFFF, 16'hFFFF);
    queue_sample(16'hFFFF, 16'h0000);
    queue_sample(16'h0000, 16'hFFFF);
  endtask

  // Random coefficients lean toward the extremes and zero, since those drive
  // the intermediate sums hardest into wrap-around.
  function automatic logic [CoefW-1:0] pick_coef();
    case ($urandom_range(7))
      0:       return 16'h7FFF;
      1:       return 16'h8000;
      2:       return 16'h0000;
      default: return CoefW'($urandom);
    endcase
  endfunction

  function automatic logic [RawW-1:0] pick_raw();
    logic [RawW-1:0] w;
    w = RawW'($urandom);
    // Now and then pin the count to an end of its range; low bits stay random.
    if ($urandom_range(3) == 0) w[RawW-1:DropW] = $urandom_range(1) ? '1 : '0;
    return w;
  endfunction

  // Stimulus: directed corners first, then random phases, each with its own
  // coefficient set and idling level. The closing phases run without idling.
  initial begin : stimulus
    coef_t k;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Coefficients straight out of reset are all zero, so the output is zero.
    idle_pct = 25;
    queue_sample(16'h0000, 16'h0000);
    queue_sample(16'hFFFF, 16'hFFFF);
    wait_drained();

    // A typical factory calibration; pressure and temperature sweep their
    // ranges and the ignored low six bits are exercised on their own.
    load_coefs('{a0: 16'h3ECE, b1: 16'hB3F9, b2: 16'hC517, c12: 16'h33C8,
                 c11: 16'h0000, c22: 16'h0000});
    queue_corners();
    queue_sample(16'h003F, 16'h003F);
    queue_sample(16'h0040, 16'h0040);
    queue_sample(16'h8000, 16'h8000);
    queue_sample(16'hFFC0, 16'hFFC0);
    wait_drained();

    // Every coefficient at its most positive, then its most negative value,
    // then alternating, to force wrap-around in the intermediate sums.
    load_coefs('{a0: 16'h7FFF, b1: 16'h7FFF, b2: 16'h7FFF, c12: 16'h7FFF,
                 c11: 16'h7FFF, c22: 16'h7FFF});
    queue_corners();
    wait_drained();
    load_coefs('{a0: 16'h8000, b1: 16'h8000, b2: 16'h8000, c12: 16'h8000,
                 c11: 16'h8000, c22: 16'h8000});
    queue_corners();
    wait_drained();
    load_coefs('{a0: 16'h7FFF, b1: 16'h8000, b2: 16'h7FFF, c12: 16'h8000,
                 c11: 16'h7FFF, c22: 16'h8000});
    queue_corners();
    wait_drained();

    for (int ph = 0; ph < RandomPhases; ph++) begin
      k = '{a0: pick_coef(), b1: pick_coef(), b2: pick_coef(), c12: pick_coef(),
            c11: pick_coef(), c22: pick_coef()};
      load_coefs(k);
      idle_pct = idle_plan[ph];
      for (int n = 0; n < PhaseRequests; n++) queue_sample(pick_raw(), pick_raw());
      wait_drained();
    end

    repeat (DrainCycles) @(posedge clk_i);
    if (expected_pressure_q.size() != 0) begin
      mismatches++;
      $display("%0t: %0d expected results never arrived", $time,
               expected_pressure_q.size());
    end
    if (mismatches == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  // Request driver: presents the next pending sample once the slot is free,
  // and after a request may take a short random break before the next one.
  always @(negedge clk_i) begin : request_driver
    sample_t s;
    if (!in_valid_i || in_taken) begin
      if (send_gap > 0) begin
        send_gap--;
        in_valid_i <= 1'b0;
      end else if (sample_q.size() > 0) begin
        s = sample_q.pop_front();
        pressure_raw_i    <= s.pressure;
        temperature_raw_i <= s.temperature;
        in_valid_i        <= 1'b1;
        if (idle_pct != 0 && $urandom_range(99) < idle_pct) send_gap = $urandom_range(1, 8);
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // Result receiver: random short stalls, plus one long hold-off so that the
  // pipeline fills and the block has to push back on incoming requests.
  always @(negedge clk_i) begin : result_receiver
    if (hold_left > 0) begin
      hold_left--;
      out_ready_i <= 1'b0;
    end else if (!long_hold_done && results_seen >= LongHoldAt) begin
      long_hold_done = 1'b1;
      hold_left = LongHoldLen - 1;
      out_ready_i <= 1'b0;
    end else if (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
      hold_left = $urandom_range(1, 8) - 1;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= 1'b1;
    end
  end

  // Monitor: checks each result against the oldest prediction, then predicts
  // the result of a request accepted at this edge.
  always @(posedge clk_i) begin : result_monitor
    logic signed [CoefW-1:0] want;
    in_taken <= in_valid_i && in_ready_o;
    if (out_valid_o && out_ready_i) begin
      results_seen <= results_seen + 1;
      if (expected_pressure_q.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected result: expected none, got %0d", $time,
                 compensated_pressure_o);
      end else begin
        want = expected_pressure_q.pop_front();
        if (compensated_pressure_o !== want) begin
          mismatches++;
          $display("%0t: compensated_pressure mismatch: expected %0d, got %0d", $time,
                   want, compensated_pressure_o);
        end
      end
    end
    if (in_valid_i && in_ready_o)
      expected_pressure_q.push_back(compensate(calib, pressure_raw_i, temperature_raw_i));
  end

  // Watchdog: ends the run if no handshake on any channel for too long.
  always @(posedge clk_i) begin : watchdog
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
        (cfg_valid_i && cfg_ready_o)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= WatchdogLimit) begin
      $display("%0t: no progress for %0d cycles", $time, WatchdogLimit);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

endmodule
